/* rtl/core/world_to_screen_projection_unit_macros.svh */
// ============================================================================
// World-to-screen projection assertion macros
// Concurrent assertion helpers shared by the projection unit RTL.
// ============================================================================
`ifndef WORLD_TO_SCREEN_PROJECTION_UNIT_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge out of reset.
`define WSP_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("projection unit assertion failed");
// Next-cycle implication, checked on every rising edge out of reset.
`define WSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("projection unit assertion failed");
`else
`define WSP_ASSERT_IMPLIES(lbl, ante, cons)
`define WSP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/wsp_pkg.sv */
// ============================================================================
// World-to-screen projection package
// Types, register codes and arithmetic helpers for the projection unit.
// ============================================================================
package wsp_pkg;

    localparam int QBITS  = 32;
    localparam int REM_W  = 64;
    localparam int MAP_W  = 48;

    localparam logic [0:0] REG_VIEWPORT_WIDTH  = 1'b0;
    localparam logic [0:0] REG_VIEWPORT_HEIGHT = 1'b1;

    localparam logic [13:0] VP_WIDTH_RST  = 14'd1024;
    localparam logic [13:0] VP_HEIGHT_RST = 14'd768;

    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_PROJECT = 1'b1;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // State carried through the divider stages, both quotients side by side.
    typedef struct packed {
        logic [REM_W-1:0] rem_x;
        logic [REM_W-1:0] rem_y;
        logic [QBITS-1:0] q_x;
        logic [QBITS-1:0] q_y;
        logic [31:0]      d;
        logic             neg_x;
        logic             neg_y;
        logic             ovf_x;
        logic             ovf_y;
        logic             behind;
    } div_t;

    // One restoring step: resolves quotient bit bit_pos of both lanes.
    function automatic div_t div_step(div_t s, int unsigned bit_pos);
        div_t             r;
        logic [REM_W-1:0] dsh;
        r   = s;
        dsh = {32'b0, s.d} << bit_pos;
        if (s.rem_x >= dsh)
        begin
            r.rem_x = s.rem_x - dsh;
            r.q_x[bit_pos[4:0]] = 1'b1;
        end
        if (s.rem_y >= dsh)
        begin
            r.rem_y = s.rem_y - dsh;
            r.q_y[bit_pos[4:0]] = 1'b1;
        end
        return r;
    endfunction

    // Clamps a signed 64-bit value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = S32_MAX;
        else if (v < -64'sh0000_0000_8000_0000)
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    // Applies the sign to a quotient magnitude and saturates it.
    function automatic logic signed [31:0] quot_fix(logic [31:0] q, logic neg, logic ovf);
        logic signed [31:0] r;
        if (ovf)
            r = neg ? S32_MIN : S32_MAX;
        else if (neg)
            r = (q > 32'h8000_0000) ? S32_MIN : -$signed(q);
        else
            r = (q > 32'h7FFF_FFFF) ? S32_MAX : $signed(q);
        return r;
    endfunction

    // Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
    function automatic logic [31:0] mag32(logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

/* rtl/core/world_to_screen_projection_unit.sv */
// ============================================================================
// World-to-screen projection unit
// Projects points through a stored 4x4 view matrix to viewport pixels.
// ============================================================================
// Stages 0 to 3, the divider stages, stages 4 and 5 and the output register
// take one item per cycle when not stalled. The 32-stage restoring divider,
// one quotient bit per stage, sets the depth; each stage has its own valid bit.
// A matrix write takes one input transfer and produces no result.
// Reset clears all valid bits and sets the viewport to 1024 x 768; the view
// matrix is not cleared and must be written before it is used.

`include "world_to_screen_projection_unit_macros.svh"

module world_to_screen_projection_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // Item input channel.
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [3:0]         entry_index,
    input  logic signed [31:0] entry_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    // Result output channel.
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] screen_x,
    output logic signed [31:0] screen_y,
    output logic               behind_viewer,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Near-plane threshold, 0.1 rounded to the fixed-point grid.
    localparam logic signed [31:0] NEAR_FX = 32'((2 ** FRAC_BITS + 5) / 10);
    localparam int NDIV = wsp_pkg::QBITS;

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the APB access phase.
    // ------------------------------------------------------------------
    logic [13:0] vp_width_reg;
    logic [13:0] vp_height_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_width_reg  <= wsp_pkg::VP_WIDTH_RST;
            vp_height_reg <= wsp_pkg::VP_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == wsp_pkg::REG_VIEWPORT_WIDTH)
                vp_width_reg <= pwdata[13:0];
            else
                vp_height_reg <= pwdata[13:0];
        end
    end

    assign prdata = (paddr[2] == wsp_pkg::REG_VIEWPORT_WIDTH) ? {18'b0, vp_width_reg}
                                                              : {18'b0, vp_height_reg};

    // ------------------------------------------------------------------
    // Pipeline registers. Each stage advances when it is empty or when
    // its successor advances, so bubbles collapse and stalls drop nothing.
    // ------------------------------------------------------------------
    logic                     v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic [NDIV-1:0]          dv_valid_reg;
    logic                     go0, go1, go2, go3, go4, go5, go_out;
    logic [NDIV-1:0]          dgo;

    logic signed [31:0]       matrix_reg [16];
    logic signed [31:0]       px_reg, py_reg, pz_reg;
    logic signed [63:0]       prod_reg [9];
    logic signed [31:0]       tx_reg, ty_reg, tw_reg;
    logic signed [31:0]       cx_reg, cy_reg, cw_reg;
    wsp_pkg::div_t            s3_reg;
    wsp_pkg::div_t            dv_reg [NDIV];
    logic signed [31:0]       nx_reg, ny_reg;
    logic                     behind4_reg, behind5_reg;
    logic signed [wsp_pkg::MAP_W-1:0] mx_reg, my_reg, offx_reg, offy_reg;
    logic signed [31:0]       sx_reg, sy_reg;
    logic                     behind_o_reg;

    always_comb
    begin
        go_out = !vo_reg || out_ready;
        go5    = !v5_reg || go_out;
        go4    = !v4_reg || go5;
        dgo[NDIV-1] = !dv_valid_reg[NDIV-1] || go4;
        for (int k = NDIV - 2; k >= 0; k--)
            dgo[k] = !dv_valid_reg[k] || dgo[k+1];
        go3 = !v3_reg || dgo[0];
        go2 = !v2_reg || go3;
        go1 = !v1_reg || go2;
        go0 = !v0_reg || go1;
    end

    assign in_ready = go0;

    // Matrix writes land on the transfer edge and never enter the pipeline.
    // A projection reads the matrix when it leaves stage 0, so any write
    // accepted on that same edge is seen only by later points.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && func == wsp_pkg::FUNC_WRITE)
            matrix_reg[entry_index] <= entry_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            vo_reg       <= 1'b0;
            dv_valid_reg <= '0;
        end
        else
        begin
            if (go0)
                v0_reg <= in_valid && func == wsp_pkg::FUNC_PROJECT;
            if (go1)
                v1_reg <= v0_reg;
            if (go2)
                v2_reg <= v1_reg;
            if (go3)
                v3_reg <= v2_reg;
            for (int k = 0; k < NDIV; k++)
            begin
                if (dgo[k])
                    dv_valid_reg[k] <= (k == 0) ? v3_reg : dv_valid_reg[k-1];
            end
            if (go4)
                v4_reg <= dv_valid_reg[NDIV-1];
            if (go5)
                v5_reg <= v4_reg;
            if (go_out)
                vo_reg <= v5_reg;
        end
    end

    // Stage 0: capture the point.
    always_ff @(posedge clk)
    begin
        if (go0)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
            pz_reg <= point_z;
        end
    end

    // Stage 1: nine exact products; entry r + 4*c is row r, column c.
    always_ff @(posedge clk)
    begin
        if (go1)
        begin
            prod_reg[0] <= 64'(px_reg) * 64'(matrix_reg[0]);
            prod_reg[1] <= 64'(py_reg) * 64'(matrix_reg[4]);
            prod_reg[2] <= 64'(pz_reg) * 64'(matrix_reg[8]);
            prod_reg[3] <= 64'(px_reg) * 64'(matrix_reg[1]);
            prod_reg[4] <= 64'(py_reg) * 64'(matrix_reg[5]);
            prod_reg[5] <= 64'(pz_reg) * 64'(matrix_reg[9]);
            prod_reg[6] <= 64'(px_reg) * 64'(matrix_reg[3]);
            prod_reg[7] <= 64'(py_reg) * 64'(matrix_reg[7]);
            prod_reg[8] <= 64'(pz_reg) * 64'(matrix_reg[11]);
            tx_reg      <= matrix_reg[12];
            ty_reg      <= matrix_reg[13];
            tw_reg      <= matrix_reg[15];
        end
    end

    // Stage 2: floor-shift each product, add the translation, saturate.
    always_ff @(posedge clk)
    begin
        if (go2)
        begin
            cx_reg <= wsp_pkg::sat32((prod_reg[0] >>> FRAC_BITS) + (prod_reg[1] >>> FRAC_BITS)
                                     + (prod_reg[2] >>> FRAC_BITS) + 64'(tx_reg));
            cy_reg <= wsp_pkg::sat32((prod_reg[3] >>> FRAC_BITS) + (prod_reg[4] >>> FRAC_BITS)
                                     + (prod_reg[5] >>> FRAC_BITS) + 64'(ty_reg));
            cw_reg <= wsp_pkg::sat32((prod_reg[6] >>> FRAC_BITS) + (prod_reg[7] >>> FRAC_BITS)
                                     + (prod_reg[8] >>> FRAC_BITS) + 64'(tw_reg));
        end
    end

    // Stage 3: divider setup. The quotient overflows 32 magnitude bits when
    // the scaled numerator reaches the divisor shifted up by 32; a zero
    // divisor always lands there, and its sign follows the numerator.
    logic [31:0]                  mag_w, mag_x, mag_y;
    logic [wsp_pkg::REM_W-1:0]    num_x, num_y, dlim;
    wsp_pkg::div_t                s3_next;

    always_comb
    begin
        mag_w = wsp_pkg::mag32(cw_reg);
        mag_x = wsp_pkg::mag32(cx_reg);
        mag_y = wsp_pkg::mag32(cy_reg);
        num_x = {32'b0, mag_x} << FRAC_BITS;
        num_y = {32'b0, mag_y} << FRAC_BITS;
        dlim  = {mag_w, 32'b0};
        s3_next        = '0;
        s3_next.rem_x  = num_x;
        s3_next.rem_y  = num_y;
        s3_next.d      = mag_w;
        s3_next.neg_x  = cx_reg[31] ^ cw_reg[31];
        s3_next.neg_y  = cy_reg[31] ^ cw_reg[31];
        s3_next.ovf_x  = num_x >= dlim;
        s3_next.ovf_y  = num_y >= dlim;
        s3_next.behind = cw_reg < NEAR_FX;
    end

    always_ff @(posedge clk)
    begin
        if (go3)
            s3_reg <= s3_next;
    end

    // Divider stages: stage k resolves quotient bit 31-k of both lanes.
    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (dgo[k])
                dv_reg[k] <= wsp_pkg::div_step((k == 0) ? s3_reg : dv_reg[(k == 0) ? 0 : k-1],
                                               unsigned'(NDIV - 1 - k));
        end
    end

    // Stage 4: sign and saturate the quotients.
    always_ff @(posedge clk)
    begin
        if (go4)
        begin
            nx_reg      <= wsp_pkg::quot_fix(dv_reg[NDIV-1].q_x, dv_reg[NDIV-1].neg_x,
                                             dv_reg[NDIV-1].ovf_x);
            ny_reg      <= wsp_pkg::quot_fix(dv_reg[NDIV-1].q_y, dv_reg[NDIV-1].neg_y,
                                             dv_reg[NDIV-1].ovf_y);
            behind4_reg <= dv_reg[NDIV-1].behind;
        end
    end

    // Stage 5: viewport scale by the integer half sizes.
    logic [12:0] half_w, half_h;

    assign half_w = vp_width_reg[13:1];
    assign half_h = vp_height_reg[13:1];

    always_ff @(posedge clk)
    begin
        if (go5)
        begin
            mx_reg      <= $signed({35'b0, half_w}) * wsp_pkg::MAP_W'(nx_reg);
            my_reg      <= $signed({35'b0, half_h}) * wsp_pkg::MAP_W'(ny_reg);
            offx_reg    <= $signed({35'b0, half_w}) <<< FRAC_BITS;
            offy_reg    <= $signed({35'b0, half_h}) <<< FRAC_BITS;
            behind5_reg <= behind4_reg;
        end
    end

    // Output register: offset, y inverted, saturate.
    always_ff @(posedge clk)
    begin
        if (go_out)
        begin
            sx_reg       <= wsp_pkg::sat32(64'(offx_reg + mx_reg));
            sy_reg       <= wsp_pkg::sat32(64'(offy_reg - my_reg));
            behind_o_reg <= behind5_reg;
        end
    end

    assign out_valid     = vo_reg;
    assign screen_x      = sx_reg;
    assign screen_y      = sy_reg;
    assign behind_viewer = behind_o_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A matrix write must not create a pipeline item.
    `WSP_ASSERT_NEXT(a_write_no_item, in_valid && in_ready && func == wsp_pkg::FUNC_WRITE,
                     !v0_reg)
    // Without overflow the final remainder is below the divisor.
    `WSP_ASSERT_IMPLIES(a_rem_x_bound, dv_valid_reg[NDIV-1] && !dv_reg[NDIV-1].ovf_x,
                        dv_reg[NDIV-1].rem_x < {32'b0, dv_reg[NDIV-1].d})
    `WSP_ASSERT_IMPLIES(a_rem_y_bound, dv_valid_reg[NDIV-1] && !dv_reg[NDIV-1].ovf_y,
                        dv_reg[NDIV-1].rem_y < {32'b0, dv_reg[NDIV-1].d})
    // A stalled setup stage keeps its item.
    `WSP_ASSERT_NEXT(a_s3_hold, v3_reg && !go3, v3_reg)

endmodule

/* tb/projection_checker.sv */
// ============================================================================
// Projection result checker
// Watches the item and result channels, computes the expected screen
// coordinates of every projected point, and compares them in order.
// ============================================================================
module projection_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               func,
    input  logic [3:0]         entry_index,
    input  logic signed [31:0] entry_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] screen_x,
    input  logic signed [31:0] screen_y,
    input  logic               behind_viewer,
    input  logic [13:0]        vp_width,
    input  logic [13:0]        vp_height,
    output int                 fail_count,
    output int                 pending_count
);

    localparam int  FRAC      = 16;
    localparam longint NEAR_W = ((64'sd1 << FRAC) + 5) / 10;

    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               behind;
    } screen_pt_t;

    logic signed [31:0] matrix_copy [16];
    screen_pt_t         screen_queue [$];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Arithmetic shift floors toward minus infinity.
    function automatic longint clip_of(int row, longint px, longint py, longint pz);
        longint s;
        s = ((px * longint'(matrix_copy[row])) >>> FRAC)
          + ((py * longint'(matrix_copy[row + 4])) >>> FRAC)
          + ((pz * longint'(matrix_copy[row + 8])) >>> FRAC)
          + longint'(matrix_copy[row + 12]);
        return clamp32(s);
    endfunction

    function automatic longint ndc_of(longint num, longint w);
        if (w == 0)
            return (num >= 0) ? 64'sd2147483647 : -64'sd2147483648;
        return clamp32((num <<< FRAC) / w);
    endfunction

    function automatic screen_pt_t project_point(longint px, longint py, longint pz);
        screen_pt_t p;
        longint     cx, cy, cw, hw, hh;
        cx = clip_of(0, px, py, pz);
        cy = clip_of(1, px, py, pz);
        cw = clip_of(3, px, py, pz);
        hw = longint'(vp_width >> 1);
        hh = longint'(vp_height >> 1);
        p.sx     = 32'(clamp32(hw * ndc_of(cx, cw) + (hw <<< FRAC)));
        p.sy     = 32'(clamp32((hh <<< FRAC) - hh * ndc_of(cy, cw)));
        p.behind = (cw < NEAR_W);
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
        foreach (matrix_copy[i])
            matrix_copy[i] = '0;
    end

    always @(posedge clk)
    begin
        screen_pt_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (func == wsp_pkg::FUNC_WRITE)
                    matrix_copy[entry_index] = entry_value;
                else
                    screen_queue.push_back(project_point(point_x, point_y, point_z));
            end
            if (out_valid && out_ready)
            begin
                if (screen_queue.size() == 0)
                    report_mismatch("unexpected result", screen_x, 0);
                else
                begin
                    want = screen_queue.pop_front();
                    if (screen_x !== want.sx)
                        report_mismatch("screen_x", screen_x, want.sx);
                    if (screen_y !== want.sy)
                        report_mismatch("screen_y", screen_y, want.sy);
                    if (behind_viewer !== want.behind)
                        report_mismatch("behind_viewer", behind_viewer, want.behind);
                end
            end
            pending_count = screen_queue.size();
        end
    end
endmodule

/* tb/tb_top.sv */
// ============================================================================
// Projection unit testbench
// Loads view matrices, projects directed and random points under random
// flow control and several viewport settings, and checks every result.
// ============================================================================
module tb_top;

    // The projection pipeline is 39 stages deep; allow a margin when draining.
    localparam int DRAIN_CYCLES = 60;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               func = wsp_pkg::FUNC_WRITE;
    logic [3:0]         entry_index = '0;
    logic signed [31:0] entry_value = '0;
    logic signed [31:0] point_x = '0;
    logic signed [31:0] point_y = '0;
    logic signed [31:0] point_z = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               behind_viewer;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // The checker keeps its own copy of the viewport, mirrored from here.
    logic [13:0]        vp_width = wsp_pkg::VP_WIDTH_RST;
    logic [13:0]        vp_height = wsp_pkg::VP_HEIGHT_RST;
    int                 fail_count;
    int                 pending_count;
    bit                 hold_off = 1'b0;

    always #5 clk = ~clk;

    world_to_screen_projection_unit dut (.*);

    projection_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .func(func),
        .entry_index(entry_index), .entry_value(entry_value),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .screen_x(screen_x), .screen_y(screen_y), .behind_viewer(behind_viewer),
        .vp_width(vp_width), .vp_height(vp_height),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // Random 32-bit value biased toward small magnitudes and extremes.
    function automatic logic [31:0] fx_value();
        unique case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000);
        endcase
    endfunction

    // Offers one item and holds it until the transfer happens. Valid stays
    // high after the transfer so that a following item can go back to back;
    // a gap or a drain drops it.
    task automatic send_item(input logic f, input logic [3:0] idx, input logic [31:0] val,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input bit gaps);
        int n;
        n = gaps ? gap_length() : 0;
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n)
                @(posedge clk);
        end
        func        <= f;
        entry_index <= idx;
        entry_value <= val;
        point_x     <= px;
        point_y     <= py;
        point_z     <= pz;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_entry(input logic [3:0] idx, input logic [31:0] val);
        send_item(wsp_pkg::FUNC_WRITE, idx, val, $urandom(), $urandom(), $urandom(), 1'b1);
    endtask

    task automatic project(input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] pz);
        send_item(wsp_pkg::FUNC_PROJECT, 4'($urandom()), $urandom(), px, py, pz, 1'b1);
    endtask

    // Register writes happen only with the pipeline empty.
    task automatic write_register(input logic [0:0] idx, input logic [13:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {18'($urandom()), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == wsp_pkg::REG_VIEWPORT_WIDTH)
            vp_width = val;
        else
            vp_height = val;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic load_random_matrix();
        for (int i = 0; i < 16; i++)
            write_entry(i[3:0], fx_value());
    endtask

    // Receiver: random stalls, plus one long hold-off so the pipeline fills up.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (300)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            n = gap_length();
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n)
                    @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        #20_000_000;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        logic [31:0] ident [16];
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity-like matrix with w = 1, so the mapping is easy to follow.
        foreach (ident[i])
            ident[i] = ((i % 5) == 0) ? 32'h0001_0000 : 32'h0;
        foreach (ident[i])
            write_entry(i[3:0], ident[i]);
        project(32'h0, 32'h0, 32'h0);
        project(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000);
        project(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        project(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        // Zero w: both numerator signs.
        write_entry(4'd15, 32'h0);
        project(32'h0001_0000, 32'hFFFF_0000, 32'h0);
        project(32'hFFFF_0000, 32'h0001_0000, 32'h0);
        // w just below and at the near threshold.
        write_entry(4'd15, 32'd6553);
        project(32'h0002_0000, 32'h0002_0000, 32'h0);
        write_entry(4'd15, 32'd6554);
        project(32'h0002_0000, 32'h0002_0000, 32'h0);
        // Tiny w makes the quotient overflow; negative w is behind.
        write_entry(4'd15, 32'd1);
        project(32'h7FFF_0000, 32'h8000_0000, 32'h0);
        write_entry(4'd15, 32'hFFFF_0000);
        project(32'h0003_0000, 32'hFFFD_0000, 32'h0);
        drain();

        // Viewport settings: odd sizes, zero and the largest.
        write_register(wsp_pkg::REG_VIEWPORT_WIDTH, 14'd1023);
        write_register(wsp_pkg::REG_VIEWPORT_HEIGHT, 14'd767);
        write_entry(4'd15, 32'h0001_0000);
        project(32'h0000_4000, 32'hFFFF_C000, 32'h0);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            unique case (phase)
                0: begin write_register(wsp_pkg::REG_VIEWPORT_WIDTH, 14'd0);
                         write_register(wsp_pkg::REG_VIEWPORT_HEIGHT, 14'd0); end
                1: begin write_register(wsp_pkg::REG_VIEWPORT_WIDTH, 14'd8192);
                         write_register(wsp_pkg::REG_VIEWPORT_HEIGHT, 14'd8192); end
                2: begin write_register(wsp_pkg::REG_VIEWPORT_WIDTH, 14'h3FFF);
                         write_register(wsp_pkg::REG_VIEWPORT_HEIGHT, 14'h3FFF); end
                default: begin
                    write_register(wsp_pkg::REG_VIEWPORT_WIDTH, 14'($urandom_range(0, 8192)));
                    write_register(wsp_pkg::REG_VIEWPORT_HEIGHT, 14'($urandom_range(0, 8192)));
                end
            endcase
            load_random_matrix();
            if (phase == 2)
                hold_off = 1'b1;
            for (int k = 0; k < 170; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    write_entry(4'($urandom()), fx_value());
                else
                    project(fx_value(), fx_value(), fx_value());
            end
            drain();
        end

        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
